>>> rtl/positional_sequence_store_macros.svh
// assertion macros used by the checker module
`ifndef POSITIONAL_SEQUENCE_STORE_MACROS_SVH
`define POSITIONAL_SEQUENCE_STORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pss_pkg.sv
package pss_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int CNT_W     = 7;
    localparam int ST_W      = 2;
    localparam int DEPTH_DEF = 64;
    // cells per first-level read group
    localparam int GRP       = 8;

    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_REM_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_REM_POS   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ      = 3'd6;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              rd_en;
        logic [CNT_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

>>> rtl/pss_cell.sv
module pss_cell #(
    parameter int IDX = 0
) (
    input  logic                          i_clk,
    input  pss_pkg::t_cell_cmd            i_cmd,
    input  logic [pss_pkg::DATA_W-1:0]    i_left,
    input  logic [pss_pkg::DATA_W-1:0]    i_right,
    output logic [pss_pkg::DATA_W-1:0]    o_data,
    output logic [pss_pkg::DATA_W-1:0]    o_read
);
    import pss_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [DATA_W-1:0] r_data;

    // insert: cells behind the gap take the left neighbour, the gap takes the new value
    // remove: cells from the gap onward take the right neighbour
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (MY_IDX > i_cmd.idx) begin
                r_data <= i_left;
            end else if (MY_IDX == i_cmd.idx) begin
                r_data <= i_cmd.value;
            end
        end else if (i_cmd.rem) begin
            if (MY_IDX >= i_cmd.idx) begin
                r_data <= i_right;
            end
        end
    end

    assign o_data = r_data;
    assign o_read = (i_cmd.rd_en && (MY_IDX == i_cmd.idx)) ? r_data : '0;

endmodule

>>> rtl/pss_ctrl.sv
module pss_ctrl #(
    parameter int DEPTH = pss_pkg::DEPTH_DEF
) (
    input  logic [pss_pkg::OP_W-1:0]    i_op,
    input  logic [pss_pkg::DATA_W-1:0]  i_value,
    input  logic [pss_pkg::POS_W-1:0]   i_pos,
    input  logic [pss_pkg::CNT_W-1:0]   i_count,
    output pss_pkg::t_cell_cmd          o_cmd,
    output logic [pss_pkg::ST_W-1:0]    o_status,
    output logic [pss_pkg::CNT_W-1:0]   o_count
);
    import pss_pkg::*;

    logic             full;
    logic             empty;
    logic             pos_zero;
    logic             ins_pos_bad;
    logic             pos_bad;
    logic [CNT_W-1:0] pos_idx;

    assign full        = (i_count >= CNT_W'(DEPTH));
    assign empty       = (i_count == '0);
    assign pos_zero    = (i_pos == '0);
    assign ins_pos_bad = pos_zero
                         || ({1'b0, i_pos} > ({1'b0, i_count} + (CNT_W+1)'(1)));
    assign pos_bad     = pos_zero || (i_pos > i_count);
    assign pos_idx     = i_pos - CNT_W'(1);

    always_comb begin
        o_cmd       = '0;
        o_cmd.value = i_value;
        o_status    = ST_OK;
        o_count     = i_count;
        unique case (i_op)
            OP_INS_FRONT, OP_INS_BACK: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_cmd.ins = 1'b1;
                    o_cmd.idx = (i_op == OP_INS_FRONT) ? '0 : i_count;
                    o_count   = i_count + CNT_W'(1);
                end
            end
            OP_INS_POS: begin
                if (ins_pos_bad) begin
                    o_status = ST_BADPOS;
                end else if (full) begin
                    o_status = ST_FULL;
                end else begin
                    o_cmd.ins = 1'b1;
                    o_cmd.idx = pos_idx;
                    o_count   = i_count + CNT_W'(1);
                end
            end
            OP_REM_FRONT, OP_REM_BACK: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    o_cmd.rem = 1'b1;
                    o_cmd.idx = (i_op == OP_REM_FRONT) ? '0 : (i_count - CNT_W'(1));
                    o_count   = i_count - CNT_W'(1);
                end
            end
            OP_REM_POS: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else if (pos_bad) begin
                    o_status = ST_BADPOS;
                end else begin
                    o_cmd.rem = 1'b1;
                    o_cmd.idx = pos_idx;
                    o_count   = i_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (pos_bad) begin
                    o_status = ST_BADPOS;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.idx   = pos_idx;
                end
            end
            default: begin
                // unused code: no change, status ok
            end
        endcase
    end

endmodule

>>> rtl/positional_sequence_store.sv
// sequence: an item is captured in idle, then the execute and read-gather steps run before the output register loads
// a new item is taken only once the previous one has left the gather step, so items never overlap in the sequencer
// a stalled result holds in the output register; the next item is still taken meanwhile
// reset: synchronous active low, clears the sequencer, element count and output valid
// element cells are not cleared; only entries below the count are ever read
module positional_sequence_store #(
    parameter int DEPTH = pss_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pss_pkg::OP_W-1:0]            i_op,
    input  logic signed [pss_pkg::DATA_W-1:0]   i_value,
    input  logic [pss_pkg::POS_W-1:0]           i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pss_pkg::ST_W-1:0]            o_status,
    output logic [pss_pkg::CNT_W-1:0]           o_count,
    output logic signed [pss_pkg::DATA_W-1:0]   o_read_value
);
    import pss_pkg::*;

    // number of first-level read groups
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    // sequencer codes
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_GATHER = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;

    // captured item
    logic [OP_W-1:0]   r_op;
    logic [DATA_W-1:0] r_value;
    logic [POS_W-1:0]  r_pos;

    // element count and pending status
    logic [CNT_W-1:0]  r_count;
    logic [ST_W-1:0]   r_status;

    // output register
    logic              r_out_valid;
    logic [ST_W-1:0]   r_out_status;
    logic [CNT_W-1:0]  r_out_count;
    logic [DATA_W-1:0] r_out_read;

    // decoder results
    t_cell_cmd         dec_cmd;
    t_cell_cmd         cell_cmd;
    logic [ST_W-1:0]   dec_status;
    logic [CNT_W-1:0]  dec_count;

    // cell chain wiring and read gather
    logic [DATA_W-1:0] w_data [DEPTH];
    logic [DATA_W-1:0] w_read [NGRP*GRP];
    logic [DATA_W-1:0] n_grp  [NGRP];
    logic [DATA_W-1:0] r_grp  [NGRP];
    logic [DATA_W-1:0] n_read;

    logic in_xfer;
    logic exec;
    logic out_free;
    logic out_load;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign exec     = (r_state == S_EXEC);
    // output register can take a result when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;
    assign out_load = (r_state == S_GATHER) && out_free;

    assign o_in_ready = (r_state == S_IDLE);

    pss_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_op     (r_op),
        .i_value  (r_value),
        .i_pos    (r_pos),
        .i_count  (r_count),
        .o_cmd    (dec_cmd),
        .o_status (dec_status),
        .o_count  (dec_count)
    );

    // cells only act in the execute cycle
    always_comb begin
        cell_cmd       = dec_cmd;
        cell_cmd.ins   = dec_cmd.ins && exec;
        cell_cmd.rem   = dec_cmd.rem && exec;
        cell_cmd.rd_en = dec_cmd.rd_en && exec;
    end

    // the chain: each cell sees its two neighbours, ends tied to zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_inner_l
            assign left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner_r
            assign right = w_data[g+1];
        end

        pss_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cell_cmd),
            .i_left  (left),
            .i_right (right),
            .o_data  (w_data[g]),
            .o_read  (w_read[g])
        );
    end

    // pad the read lines up to a whole number of groups
    for (genvar g = DEPTH; g < NGRP*GRP; g++) begin : g_pad
        assign w_read[g] = '0;
    end

    // first level of the read tree: or within each group of cells
    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        always_comb begin
            n_grp[g] = '0;
            for (int k = 0; k < GRP; k++) begin
                n_grp[g] = n_grp[g] | w_read[g*GRP + k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (exec) begin
                r_grp[g] <= n_grp[g];
            end
        end
    end

    // second level: or across the registered groups
    always_comb begin
        n_read = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_read = n_read | r_grp[g];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_GATHER;
            end
            S_GATHER: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec) begin
                r_count <= dec_count;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (exec) begin
            r_status <= dec_status;
        end
        if (out_load) begin
            r_out_status <= r_status;
            r_out_count  <= r_count;
            r_out_read   <= n_read;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
    assign o_read_value = r_out_read;

endmodule

>>> rtl/pss_checker.sv
`include "positional_sequence_store_macros.svh"

module pss_checker #(
    parameter int DEPTH = pss_pkg::DEPTH_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [pss_pkg::ST_W-1:0]            o_status,
    input logic [pss_pkg::CNT_W-1:0]           o_count,
    input logic signed [pss_pkg::DATA_W-1:0]   o_read_value
);
    import pss_pkg::*;

    `PSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `PSS_ASSERT_NOW(a_count_max, i_clk, i_rst_n,
        o_out_valid, o_count <= CNT_W'(DEPTH), "count above depth")
    `PSS_ASSERT_NOW(a_full_count, i_clk, i_rst_n,
        o_out_valid && (o_status == ST_FULL), o_count == CNT_W'(DEPTH),
        "full status with room left")
    `PSS_ASSERT_NOW(a_empty_count, i_clk, i_rst_n,
        o_out_valid && (o_status == ST_EMPTY), o_count == '0,
        "empty status with elements stored")
    `PSS_ASSERT_NOW(a_read_ok, i_clk, i_rst_n,
        o_out_valid && (o_read_value != '0), o_status == ST_OK,
        "read data on a failed operation")

endmodule

bind positional_sequence_store pss_checker #(
    .DEPTH (DEPTH)
) u_pss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_status     (o_status),
    .o_count      (o_count),
    .o_read_value (o_read_value)
);

>>> verif/pss_result_checker.sv
`timescale 1ns / 1ps

module pss_result_checker #(
    parameter int DEPTH = pss_pkg::DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [pss_pkg::OP_W-1:0]            i_op,
    input  logic signed [pss_pkg::DATA_W-1:0]   i_value,
    input  logic [pss_pkg::POS_W-1:0]           i_position,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [pss_pkg::ST_W-1:0]            i_status,
    input  logic [pss_pkg::CNT_W-1:0]           i_count,
    input  logic signed [pss_pkg::DATA_W-1:0]   i_read_value,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import pss_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] read_value;
    } t_store_result;

    logic signed [DATA_W-1:0] shadow_cells [DEPTH];
    int                       shadow_count = 0;
    t_store_result            awaited_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // shift later entries back by one and place the new value
    function automatic void open_gap(int idx, logic signed [DATA_W-1:0] v);
        for (int i = shadow_count; i > idx; i--) begin
            shadow_cells[i] = shadow_cells[i-1];
        end
        shadow_cells[idx] = v;
        shadow_count++;
    endfunction

    // shift later entries forward by one over the removed one
    function automatic void close_gap(int idx);
        for (int i = idx; i + 1 < shadow_count; i++) begin
            shadow_cells[i] = shadow_cells[i+1];
        end
        shadow_count--;
    endfunction

    function automatic void apply_operation(logic [OP_W-1:0] op,
                                            logic signed [DATA_W-1:0] v,
                                            logic [POS_W-1:0] pos);
        t_store_result res;
        int            p;
        res.status     = ST_OK;
        res.read_value = '0;
        p = int'(pos);
        case (op)
            OP_INS_FRONT, OP_INS_BACK: begin
                if (shadow_count >= DEPTH)
                    res.status = ST_FULL;
                else
                    open_gap((op == OP_INS_FRONT) ? 0 : shadow_count, v);
            end
            OP_INS_POS: begin
                // position is checked before fullness
                if (p < 1 || p > shadow_count + 1)
                    res.status = ST_BADPOS;
                else if (shadow_count >= DEPTH)
                    res.status = ST_FULL;
                else
                    open_gap(p - 1, v);
            end
            OP_REM_FRONT, OP_REM_BACK: begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else
                    close_gap((op == OP_REM_FRONT) ? 0 : shadow_count - 1);
            end
            OP_REM_POS: begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else if (p < 1 || p > shadow_count)
                    res.status = ST_BADPOS;
                else
                    close_gap(p - 1);
            end
            OP_READ: begin
                if (p < 1 || p > shadow_count)
                    res.status = ST_BADPOS;
                else
                    res.read_value = shadow_cells[p-1];
            end
            default: begin
            end
        endcase
        res.count = CNT_W'(shadow_count);
        awaited_results.push_back(res);
    endfunction

    function automatic void check_result();
        t_store_result want;
        t_store_result got;
        got.status     = i_status;
        got.count      = i_count;
        got.read_value = i_read_value;
        if (awaited_results.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: result with nothing outstanding: status %0d count %0d value %0d",
                         $realtime, got.status, got.count, got.read_value);
        end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.count !== want.count ||
                got.read_value !== want.read_value) begin
                o_fail_count++;
                if (o_fail_count <= 10)
                    $display(
                        "%0t: expected st %0d cnt %0d val %0d, got st %0d cnt %0d val %0d",
                        $realtime, want.status, want.count, want.read_value,
                        got.status, got.count, got.read_value);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                apply_operation(i_op, i_value, i_position);
        end
        o_pending = awaited_results.size();
    end

endmodule

>>> verif/tb_positional_sequence_store.sv
`timescale 1ns / 1ps

module tb_positional_sequence_store;
    import pss_pkg::*;

    localparam int STORE_DEPTH = DEPTH_DEF;
    // op code the block ignores; it still answers with a plain result
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 1750;
    // closing stretch of the random part with no idling on either side
    localparam int CALM_ITEMS = 150;
    // receiver long hold-off, and when it starts
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_START = 1500;

    // bias of the random part: grow the store, shrink it, or wander
    typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIX} t_phase_mode;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [OP_W-1:0]          in_op = OP_READ;
    logic signed [DATA_W-1:0] in_value = '0;
    logic [POS_W-1:0]         in_position = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [ST_W-1:0]          out_status;
    logic [CNT_W-1:0]         out_count;
    logic signed [DATA_W-1:0] out_read_value;

    int fail_count;
    int pending;
    // element count once every item sent so far has taken effect
    int stored_count = 0;
    // set near the end so both sides stop idling
    bit calm = 1'b0;

    positional_sequence_store #(
        .DEPTH(STORE_DEPTH)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_op         (in_op),
        .i_value      (in_value),
        .i_position   (in_position),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_status     (out_status),
        .o_count      (out_count),
        .o_read_value (out_read_value)
    );

    pss_result_checker #(
        .DEPTH(STORE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_op         (in_op),
        .i_value      (in_value),
        .i_position   (in_position),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_status     (out_status),
        .i_count      (out_count),
        .i_read_value (out_read_value),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // element count after one item, only used to steer positions into range
    function automatic int stored_count_after(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                              int cnt);
        case (op)
            OP_INS_FRONT, OP_INS_BACK: begin
                return (cnt < STORE_DEPTH) ? cnt + 1 : cnt;
            end
            OP_INS_POS: begin
                return (pos >= 1 && pos <= cnt + 1 && cnt < STORE_DEPTH) ? cnt + 1 : cnt;
            end
            OP_REM_FRONT, OP_REM_BACK: begin
                return (cnt > 0) ? cnt - 1 : cnt;
            end
            OP_REM_POS: begin
                return (pos >= 1 && pos <= cnt) ? cnt - 1 : cnt;
            end
            default: begin
                return cnt;
            end
        endcase
    endfunction

    // offer one item and hold it until the transfer happens
    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] v,
                             input logic [POS_W-1:0] pos);
        in_valid    <= 1'b1;
        in_op       <= op;
        in_value    <= v;
        in_position <= pos;
        do @(posedge clk); while (!in_ready);
        stored_count = stored_count_after(op, pos, stored_count);
    endtask

    // result side: short random stalls, one long hold-off so the block backs up,
    // and a steady ready once the run turns calm
    initial begin : result_sink
        int cycles_seen;
        int n;
        bit long_hold_done;
        cycles_seen    = 0;
        long_hold_done = 1'b0;
        wait (rst_n);
        forever begin
            if (!long_hold_done && cycles_seen >= LONG_HOLD_START) begin
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                cycles_seen += LONG_HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 10);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                cycles_seen += n;
            end else begin
                n = $urandom_range(1, 12);
                out_ready <= 1'b1;
                repeat (n) @(posedge clk);
                cycles_seen += n;
            end
        end
    end

    initial begin : stimulus
        t_phase_mode              mode;
        int                       phase_left;
        int                       sent;
        int                       roll;
        int                       ins_pct;
        int                       top_pos;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         pos;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store: reads and removes of every kind, bad insert positions
        send_item(OP_READ, 32'sd0, 7'd1);
        send_item(OP_REM_FRONT, 32'sd0, 7'd0);
        send_item(OP_REM_BACK, 32'sd0, 7'd0);
        send_item(OP_REM_POS, 32'sd0, 7'd127);
        send_item(OP_INS_POS, 32'sd5, 7'd0);
        send_item(OP_INS_POS, 32'sd5, 7'd2);

        // build min, 0, max, -1 then push a pattern in at the front
        send_item(OP_INS_FRONT, 32'sh8000_0000, 7'd0);
        send_item(OP_INS_BACK, 32'sh7fff_ffff, 7'd127);
        send_item(OP_INS_POS, 32'sd0, 7'd2);
        send_item(OP_INS_POS, -32'sd1, 7'd4);
        send_item(OP_INS_POS, 32'sh5555_aaaa, 7'd1);

        // walk every valid position, then read out of range on both sides
        for (int p = 1; p <= 5; p++) begin
            send_item(OP_READ, 32'sd0, POS_W'(p));
        end
        send_item(OP_READ, 32'sd0, 7'd0);
        send_item(OP_READ, 32'sd0, 7'd6);
        send_item(OP_READ, 32'sd0, 7'd127);
        send_item(OP_REM_POS, 32'sd0, 7'd0);
        send_item(OP_REM_POS, 32'sd0, 7'd6);
        send_item(OP_UNUSED, 32'sh1234_5678, 7'd3);

        // take from the middle, the front and the back
        send_item(OP_REM_POS, 32'sd0, 7'd3);
        send_item(OP_REM_FRONT, 32'sd0, 7'd0);
        send_item(OP_REM_BACK, 32'sd0, 7'd0);
        send_item(OP_READ, 32'sd0, 7'd1);

        // random part: first phase fills the store so the full cases come early
        sent       = 0;
        mode       = MODE_FILL;
        phase_left = 140;
        while (sent < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                mode       = t_phase_mode'($urandom_range(0, 2));
                phase_left = $urandom_range(20, 120);
            end
            if (sent == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;

            case (mode)
                MODE_FILL:  ins_pct = 70;
                MODE_DRAIN: ins_pct = 15;
                default:    ins_pct = 40;
            endcase

            // pick an op class: rare unused code, inserts, reads, removes
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                op = OP_UNUSED;
            end else if (roll < 2 + ins_pct) begin
                case ($urandom_range(0, 2))
                    0:       op = OP_INS_FRONT;
                    1:       op = OP_INS_BACK;
                    default: op = OP_INS_POS;
                endcase
            end else if (roll < 17 + ins_pct) begin
                op = OP_READ;
            end else begin
                case ($urandom_range(0, 2))
                    0:       op = OP_REM_FRONT;
                    1:       op = OP_REM_BACK;
                    default: op = OP_REM_POS;
                endcase
            end

            // mostly a legal position, otherwise zero, just past the end, the top or noise
            top_pos = (op == OP_INS_POS) ? stored_count + 1 : stored_count;
            if ($urandom_range(0, 9) != 0 && top_pos >= 1) begin
                pos = POS_W'($urandom_range(1, top_pos));
            end else begin
                case ($urandom_range(0, 3))
                    0:       pos = '0;
                    1:       pos = POS_W'(top_pos + 1);
                    2:       pos = '1;
                    default: pos = POS_W'($urandom);
                endcase
            end

            // values lean on the extremes now and then
            case ($urandom_range(0, 7))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7fff_ffff;
                2:       v = 32'sd0;
                3:       v = -32'sd1;
                default: v = $urandom;
            endcase

            // sender gap before this item
            if (!calm && $urandom_range(0, 4) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end

            send_item(op, v, pos);
            sent++;
            phase_left--;
        end

        // drain: all outstanding results, then keep the clock running to catch strays
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/pss_pkg.sv
rtl/pss_cell.sv
rtl/pss_ctrl.sv
rtl/positional_sequence_store.sv
rtl/pss_checker.sv
verif/pss_result_checker.sv
verif/tb_positional_sequence_store.sv
